/* design/ttl_pkg.sv */
// Shared types for the text token lexer: transaction payloads, token kinds,
// scan modes and the result pair handed from the scanner to the output queue.
// No dependencies.
package ttl_pkg;

   localparam int unsigned DEF_MAX_TEXT_LENGTH = 32'd65535;
   localparam int unsigned QUEUE_DEPTH = 3;

   typedef enum logic [2:0] {
      KIND_NEWLINE = 3'd0,
      KIND_SPACE   = 3'd1,
      KIND_STRING  = 3'd2,
      KIND_UNTERM  = 3'd3,
      KIND_NUMBER  = 3'd4,
      KIND_MINUS   = 3'd5,
      KIND_IDENT   = 3'd6,
      KIND_INVALID = 3'd7
   } kind_type;

   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_CR     = 3'd1,
      MODE_SPACE  = 3'd2,
      MODE_STRING = 3'd3,
      MODE_NUMBER = 3'd4,
      MODE_IDENT  = 3'd5
   } mode_type;

   typedef struct packed {
      logic [7:0] char_in;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      kind_type    token_kind;
      logic [15:0] text_start;
      logic [15:0] text_length;
      logic        final_token;
      logic        last_of_run;
   } rsp_type;

   typedef struct packed {
      logic [1:0] count;
      rsp_type    first;
      rsp_type    second;
   } scan_out_type;

endpackage

/* design/ttl_scan.sv */
// Lexer scanner: running scan state and the single-pass token decision for
// one character, giving up to two tokens per transaction. Depends on ttl_pkg.
module ttl_scan #(
   parameter int unsigned MAX_TEXT_LENGTH = ttl_pkg::DEF_MAX_TEXT_LENGTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  ttl_pkg::req_type      item,
   output ttl_pkg::scan_out_type result
);
   import ttl_pkg::*;

   localparam logic [15:0] BOUND =
      (MAX_TEXT_LENGTH < 32'd65535) ? 16'(MAX_TEXT_LENGTH) : 16'hFFFF;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_DQ    = 8'h22;
   localparam logic [7:0] CH_SQ    = 8'h27;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_US    = 8'h5F;
   localparam logic [7:0] CH_BSL   = 8'h5C;
   localparam logic [7:0] CH_E     = 8'h65;

   function automatic logic digit_char(logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic alpha_char(logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_space(logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB);
   endfunction

   function automatic logic [15:0] clamp(logic [16:0] v);
      return (v > {1'b0, BOUND}) ? BOUND : v[15:0];
   endfunction

   function automatic logic [16:0] span(logic [16:0] from, logic [16:0] upto);
      return (upto > from) ? {1'b0, clamp(upto - from)} : 17'd0;
   endfunction

   function automatic rsp_type make_tok(kind_type k, logic [16:0] s, logic [16:0] l);
      rsp_type t;
      t.token_kind  = k;
      t.text_start  = clamp(s);
      t.text_length = clamp(l);
      t.final_token = 1'b0;
      t.last_of_run = 1'b0;
      return t;
   endfunction

   mode_type    scan_mode_ff, scan_mode_in;
   logic [15:0] token_start_ff, token_start_in;
   logic [15:0] char_position_ff, char_position_in;
   logic        escape_pending_ff, escape_pending_in;
   logic        quote_is_double_ff, quote_is_double_in;

   logic [7:0]  c;
   logic [16:0] pos, pos1, ts, ts1, flush_len;
   logic        consumed, flush;
   kind_type    flush_kind;
   logic [1:0]  n;
   rsp_type     tok [2];

   always_comb begin
      c = item.char_in;
      pos = {1'b0, char_position_ff};
      pos1 = pos + 17'd1;
      ts = {1'b0, token_start_ff};
      ts1 = ts + 17'd1;
      consumed = 1'b0;
      flush = 1'b0;
      flush_kind = KIND_NEWLINE;
      flush_len = 17'd0;
      scan_mode_in = scan_mode_ff;
      token_start_in = token_start_ff;
      char_position_in = char_position_ff;
      escape_pending_in = escape_pending_ff;
      quote_is_double_in = quote_is_double_ff;
      n = 2'd0;
      tok[0] = '0;
      tok[1] = '0;

      unique case (scan_mode_ff)
         MODE_CR: begin
            if (c == CH_LF) begin
               tok[n[0]] = make_tok(KIND_NEWLINE, ts, span(ts, pos1));
               consumed = 1'b1;
            end else begin
               tok[n[0]] = make_tok(KIND_NEWLINE, ts, span(ts, pos));
            end
            n = n + 2'd1;
            scan_mode_in = MODE_IDLE;
         end
         MODE_SPACE: begin
            if (is_space(c)) begin
               consumed = 1'b1;
            end else begin
               tok[n[0]] = make_tok(KIND_SPACE, ts, span(ts, pos));
               n = n + 2'd1;
               scan_mode_in = MODE_IDLE;
            end
         end
         MODE_NUMBER: begin
            if (digit_char(c) || c == CH_DOT || c == CH_MINUS || c == CH_E) begin
               consumed = 1'b1;
            end else begin
               tok[n[0]] = make_tok(KIND_NUMBER, ts, span(ts, pos));
               n = n + 2'd1;
               scan_mode_in = MODE_IDLE;
            end
         end
         MODE_IDENT: begin
            if (alpha_char(c) || digit_char(c) || c == CH_US) begin
               consumed = 1'b1;
            end else begin
               tok[n[0]] = make_tok(KIND_IDENT, ts, span(ts, pos));
               n = n + 2'd1;
               scan_mode_in = MODE_IDLE;
            end
         end
         MODE_STRING: begin
            consumed = 1'b1;
            if (escape_pending_ff) begin
               escape_pending_in = 1'b0;
            end else if (c == (quote_is_double_ff ? CH_DQ : CH_SQ)) begin
               tok[n[0]] = make_tok(KIND_STRING, ts1, span(ts1, pos));
               n = n + 2'd1;
               scan_mode_in = MODE_IDLE;
            end else if (c == CH_BSL) begin
               escape_pending_in = 1'b1;
            end
         end
         default: begin
            scan_mode_in = MODE_IDLE;
         end
      endcase

      if (!consumed) begin
         token_start_in = char_position_ff;
         escape_pending_in = 1'b0;
         priority if (c == CH_CR) begin
            scan_mode_in = MODE_CR;
         end else if (c == CH_LF) begin
            tok[n[0]] = make_tok(KIND_NEWLINE, pos, 17'd1);
            n = n + 2'd1;
         end else if (is_space(c)) begin
            scan_mode_in = MODE_SPACE;
         end else if (c == CH_SQ || c == CH_DQ) begin
            scan_mode_in = MODE_STRING;
            quote_is_double_in = (c == CH_DQ);
         end else if (digit_char(c)) begin
            scan_mode_in = MODE_NUMBER;
         end else if (c == CH_MINUS) begin
            tok[n[0]] = make_tok(KIND_MINUS, pos, 17'd1);
            n = n + 2'd1;
         end else if (alpha_char(c) || c == CH_US) begin
            scan_mode_in = MODE_IDENT;
         end else begin
            tok[n[0]] = make_tok(KIND_INVALID, pos, 17'd1);
            n = n + 2'd1;
         end
      end

      if (item.end_of_text) begin
         flush_len = span({1'b0, token_start_in}, pos1);
         flush = 1'b1;
         unique case (scan_mode_in)
            MODE_CR:     flush_kind = KIND_NEWLINE;
            MODE_SPACE:  flush_kind = KIND_SPACE;
            MODE_NUMBER: flush_kind = KIND_NUMBER;
            MODE_IDENT:  flush_kind = KIND_IDENT;
            MODE_STRING: flush_kind = KIND_UNTERM;
            default:     flush = 1'b0;
         endcase
         if (flush) begin
            tok[n[0]] = make_tok(flush_kind, {1'b0, token_start_in}, flush_len);
            n = n + 2'd1;
         end
         if (n != 2'd0) begin
            tok[n[1]].final_token = 1'b1;
         end
         scan_mode_in = MODE_IDLE;
         token_start_in = 16'd0;
         char_position_in = 16'd0;
         escape_pending_in = 1'b0;
      end else begin
         char_position_in = clamp(pos1);
      end

      if (n != 2'd0) begin
         tok[n[1]].last_of_run = 1'b1;
      end
   end

   assign result.count  = n;
   assign result.first  = tok[0];
   assign result.second = tok[1];

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_mode_ff <= MODE_IDLE;
         token_start_ff <= 16'd0;
         char_position_ff <= 16'd0;
         escape_pending_ff <= 1'b0;
         quote_is_double_ff <= 1'b0;
      end else if (advance) begin
         scan_mode_ff <= scan_mode_in;
         token_start_ff <= token_start_in;
         char_position_ff <= char_position_in;
         escape_pending_ff <= escape_pending_in;
         quote_is_double_ff <= quote_is_double_in;
      end
   end

   a_eot_restart: assert property (@(posedge clock) disable iff (reset)
      advance && item.end_of_text |=> scan_mode_ff == MODE_IDLE && char_position_ff == 16'd0)
      else $error("scan state not restarted after end of text");

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      char_position_ff <= BOUND && token_start_ff <= BOUND)
      else $error("position beyond saturation bound");

   a_pair_order: assert property (@(posedge clock) disable iff (reset)
      result.count == 2'd2 |-> !result.first.last_of_run && !result.first.final_token
                               && result.second.last_of_run)
      else $error("first of two tokens marked as last");

endmodule

/* design/ttl_rsp_queue.sv */
// Three-entry result queue: takes up to two tokens per cycle from the scanner
// and presents one per cycle on rsp_ while rsp_ready is high. Depends on ttl_pkg.
module ttl_rsp_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ttl_pkg::scan_out_type push_data,
   output logic [1:0]            fill,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output ttl_pkg::rsp_type      rsp_data
);
   import ttl_pkg::*;

   rsp_type    slot_ff [QUEUE_DEPTH];
   rsp_type    slot_in [QUEUE_DEPTH];
   logic [1:0] count_ff, count_in;
   logic       pop;
   logic [1:0] base, push_count;

   assign pop = rsp_valid && rsp_ready;
   assign push_count = push ? push_data.count : 2'd0;
   assign base = count_ff - {1'b0, pop};

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_in[i] = slot_ff[i];
         if (pop && i < QUEUE_DEPTH - 1) begin
            slot_in[i] = slot_ff[i + 1];
         end
         if (push_count != 2'd0 && 2'(i) == base) begin
            slot_in[i] = push_data.first;
         end
         if (push_count == 2'd2 && 2'(i) == base + 2'd1) begin
            slot_in[i] = push_data.second;
         end
      end
      count_in = base + push_count;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

   assign fill = count_ff;
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_data = slot_ff[0];

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      {1'b0, base} + {1'b0, push_count} <= 3'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> count_ff == 2'd0)
      else $error("result queue not empty after reset");

   a_drain: assert property (@(posedge clock) disable iff (reset)
      pop && push_count == 2'd0 |=> count_ff == $past(count_ff) - 2'd1)
      else $error("result queue count lost a transaction");

endmodule

/* design/text_token_lexer.sv */
// Text token lexer: one byte per transaction on req_, tokens on rsp_.
// Each request carries a byte and an end-of-text flag; each response carries
// token kind, text start, text length and the final_token / last_of_run flags.
// A byte may close a pending token and emit another, so one request gives
// zero, one or two responses, in order.
// A request accepted on req_ is held in the input register and scanned from
// there; its tokens enter the result queue, whose head drives rsp_.
// Throughput: one request per cycle while each gives at most one response and
// rsp_ready stays high; the response side then runs at one token per cycle,
// so a two-token request costs the queue one extra slot. Acceptance stalls only
// when the three-entry result queue lacks room for the held request's tokens.
// A stalled receiver fills the queue, then the input register holds, then
// req_ready falls; nothing is dropped.
// Reset (synchronous) empties the input register and the queue and puts the
// scanner at offset zero with no token pending. Depends on ttl_pkg, ttl_scan
// and ttl_rsp_queue.
module text_token_lexer #(
   parameter int unsigned MAX_TEXT_LENGTH = ttl_pkg::DEF_MAX_TEXT_LENGTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  ttl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output ttl_pkg::rsp_type rsp_data
);
   import ttl_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_type      in_data_ff;
   scan_out_type scan_result;
   logic [1:0]   fill;
   logic         advance;

   assign advance = in_valid_ff &&
      ({1'b0, fill} + {1'b0, scan_result.count} <= 3'(QUEUE_DEPTH));
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   ttl_scan #(
      .MAX_TEXT_LENGTH(MAX_TEXT_LENGTH)
   ) u_scan (
      .clock  (clock),
      .reset  (reset),
      .advance(advance),
      .item   (in_data_ff),
      .result (scan_result)
   );

   ttl_rsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (advance),
      .push_data(scan_result),
      .fill     (fill),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data)
   );

endmodule
